FILE: hw/rtl/positional_list_store_macros.svh
// ----------------------------------------------------------------------------
// Positional list store assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define PLS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the same edge.
`define PLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Sizes, operation and status codes, and the command carried down the cells.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int GRP_SIZE   = 8;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int ST_W   = 2;
    localparam int ECNT_W = 7;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int NGRP   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_OVERWRITE = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic                  shift_up;
        logic                  shift_down;
        logic                  write;
        logic [IDX_W-1:0]      pos;
        logic [IDX_W-1:0]      rd_pos;
        logic [VALUE_BITS-1:0] data;
    } chain_cmd_t;

    function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [WORD_W-1:0] v);
        logic signed [VALUE_BITS-1:0] s;
        begin
            s = VALUE_BITS'(v);
            return s;
        end
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input logic [VALUE_BITS-1:0] v);
        return WORD_W'(signed'(v));
    endfunction

endpackage

FILE: hw/rtl/pls_if.sv
// ----------------------------------------------------------------------------
// Positional list store channels
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface pls_cmd_if
    import pls_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, op, position, value, input ready);
    modport sink (input valid, op, position, value, output ready);
endinterface

interface pls_rsp_if
    import pls_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [ECNT_W-1:0]        entry_count;

    modport source (output valid, read_value, status, entry_count, input ready);
    modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

FILE: hw/rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// Positional list store cell
// One list entry: shifts up or down with its neighbors, takes a write at its
// own index, and offers its value when selected for a read.
// ----------------------------------------------------------------------------
module pls_cell
    import pls_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      idx,
    input  chain_cmd_t            cmd,
    input  logic [VALUE_BITS-1:0] left_data,
    input  logic [VALUE_BITS-1:0] right_data,
    output logic [VALUE_BITS-1:0] data,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] data_reg;
    logic [VALUE_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            if (idx == cmd.pos)
            begin
                data_next = cmd.data;
            end
            else if (idx > cmd.pos)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.shift_down)
        begin
            data_next = right_data;
        end
        else if (cmd.write && (idx == cmd.pos))
        begin
            data_next = cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (idx == cmd.rd_pos) ? data_reg : '0;

endmodule

FILE: hw/rtl/pls_chain.sv
// ----------------------------------------------------------------------------
// Positional list store cell chain
// The row of entry cells and a registered two-level tree that gathers the
// selected entry for a read.
// ----------------------------------------------------------------------------
module pls_chain
    import pls_pkg::*;
(
    input  logic                  clk,
    input  chain_cmd_t            cmd,
    output logic [VALUE_BITS-1:0] rd_word
);

    logic [VALUE_BITS-1:0] cell_data [DEPTH];
    logic [VALUE_BITS-1:0] cell_rd   [DEPTH];
    logic [VALUE_BITS-1:0] grp_reg   [NGRP];
    logic [VALUE_BITS-1:0] grp_next  [NGRP];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_w;
        logic [VALUE_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pls_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if (g * GRP_SIZE + k < DEPTH)
                begin
                    grp_next[g] = grp_next[g] | cell_rd[g * GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            rd_word = rd_word | grp_reg[g];
        end
    end

endmodule

FILE: hw/rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// Positional list store
// A bounded ordered list of values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The cmd channel takes one operation word: append, insert at the front,
// insert at a position, overwrite, remove from the front, or read. The rsp
// channel returns one result word for each operation with the value read or
// removed, a status and the entry count after the operation.
// An operation is decoded and applied to every cell in the cycle it is
// accepted, so a shift of the whole list is done at once. The read value then
// passes one registered stage of the gathering tree and then the output
// register, after which the result word is valid.
// One operation is in flight at a time: no new word is accepted while the
// previous one is held in the read tree stage.
// The result sits in an output register; a new word is accepted in the same
// cycle that the previous result is taken. While rsp stalls, cmd is held off.
// Reset empties the list at once; entry contents are not cleared and are
// never read before being written.
// ----------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store
    import pls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pls_cmd_if.sink   cmd,
    pls_rsp_if.source rsp
);

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  pos_gt;
    logic                  pos_ge;
    status_t               st;
    logic                  rd_ok;
    chain_cmd_t            cc;
    logic [VALUE_BITS-1:0] rd_word;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pend_reg;
    logic              pend_rd_reg;
    status_t           pend_st_reg;
    logic              rsp_valid_reg;
    logic [WORD_W-1:0] rsp_value_reg;
    status_t           rsp_st_reg;
    logic [CNT_W-1:0]  rsp_cnt_reg;

    assign cmd.ready = !pend_reg && (!rsp_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pos_gt = (32'(cmd.position) > 32'(count_reg));
    assign pos_ge = (32'(cmd.position) >= 32'(count_reg));

    always_comb
    begin
        st            = ST_OK;
        rd_ok         = 1'b0;
        cc.shift_up   = 1'b0;
        cc.shift_down = 1'b0;
        cc.write      = 1'b0;
        cc.pos        = IDX_W'(cmd.position);
        cc.rd_pos     = IDX_W'(cmd.position);
        cc.data       = to_store(cmd.value);
        count_next    = count_reg;
        case (cmd.op)
            OP_APPEND:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cc.shift_up = 1'b1;
                    cc.pos      = IDX_W'(count_reg);
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_INS_FRONT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cc.shift_up = 1'b1;
                    cc.pos      = '0;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_INS_POS:
            begin
                if (pos_gt)
                begin
                    st = ST_RANGE;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cc.shift_up = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_OVERWRITE:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_ge)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    cc.write = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    cc.shift_down = 1'b1;
                    cc.rd_pos     = '0;
                    rd_ok         = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_ge)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        if (!accept)
        begin
            cc.shift_up   = 1'b0;
            cc.shift_down = 1'b0;
            cc.write      = 1'b0;
            count_next    = count_reg;
        end
    end

    pls_chain u_chain (
        .clk     (clk),
        .cmd     (cc),
        .rd_word (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept;
            if (pend_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_rd_reg <= rd_ok;
            pend_st_reg <= st;
        end
        if (pend_reg)
        begin
            rsp_value_reg <= pend_rd_reg ? to_word(rd_word) : '0;
            rsp_st_reg    <= pend_st_reg;
            rsp_cnt_reg   <= count_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_value_reg;
    assign rsp.status      = rsp_st_reg;
    assign rsp.entry_count = ECNT_W'(rsp_cnt_reg);

    `PLS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "count above depth")
    `PLS_ASSERT_SAME(a_pend_out_free, pend_reg, !rsp_valid_reg, "result register busy")
    `PLS_ASSERT_NEXT(a_accept_pend, accept, pend_reg && !cmd.ready, "accept not pending")
    `PLS_ASSERT_NEXT(a_remove_count, accept && (cmd.op == OP_REMOVE) && !empty,
                     count_reg == $past(count_reg) - 1'b1, "remove count mismatch")
    `PLS_ASSERT_SAME(a_err_zero, rsp_valid_reg && (rsp_st_reg != ST_OK),
                     rsp_value_reg == '0, "error result carries a value")

endmodule
